/* rtl/core/slc_pkg.sv */
// Shared types, codes and letter constants of the signal light lockout controller.
// Used by the front end, queue, back end and top level of the block and by its port checker.
package slc_pkg;

    // Result limits of one input item
    localparam int NET_SLOTS   = 40;
    localparam int MAX_RESULTS = 32;

    // Decoded-request queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // Input command codes
    localparam logic [1:0] CMD_MSG   = 2'd0;
    localparam logic [1:0] CMD_FAULT = 2'd1;
    localparam logic [1:0] CMD_JOIN  = 2'd2;

    // Sender types
    localparam logic [1:0] STYPE_CTRL    = 2'd0;
    localparam logic [1:0] STYPE_SPECIAL = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_CONF = 2'd0;
    localparam logic [1:0] KIND_IND  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_JOIN = 2'd3;

    // Message letters
    localparam logic [7:0] LTR_G = "G";
    localparam logic [7:0] LTR_Y = "Y";
    localparam logic [7:0] LTR_R = "R";
    localparam logic [7:0] LTR_O = "O";
    localparam logic [7:0] LTR_C = "C";
    localparam logic [7:0] LTR_S = "S";
    localparam logic [7:0] CONF_G = "g";
    localparam logic [7:0] CONF_Y = "y";
    localparam logic [7:0] CONF_R = "r";
    localparam logic [7:0] CONF_O = "o";
    localparam logic [7:0] CONF_C = "c";
    localparam logic [7:0] CONF_NONE = 8'h00;

    localparam logic [7:0] ALL_TARGET = 8'hFF;
    localparam logic [7:0] JOIN_CODE  = 8'hFF;

    typedef enum logic [1:0] {
        OP_CTRL,
        OP_SPECIAL,
        OP_FAULT,
        OP_JOIN
    } t_op_kind;

    typedef enum logic [3:0] {
        REQ_NONE,
        REQ_G,
        REQ_Y,
        REQ_R,
        REQ_O,
        REQ_CLR_R,
        REQ_CLR_Y,
        REQ_CLR_G,
        REQ_CLR_X
    } t_req;

    typedef enum logic [2:0] {
        MODE_CLEAR,
        MODE_GREEN,
        MODE_YELLOW,
        MODE_RED,
        MODE_STOP
    } t_mode;

    typedef enum logic [1:0] {
        COL_OFF,
        COL_GREEN,
        COL_YELLOW,
        COL_RED
    } t_colour;

    typedef struct packed {
        t_op_kind    kind;
        t_req        req;
        logic [7:0]  sender;
        logic [7:0]  net;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_APPLY,
        S_CONF,
        S_OFF,
        S_SOLID,
        S_ERR_RD,
        S_ERR_MATCH,
        S_ERR_DECIDE,
        S_ERR_LAST,
        S_JOIN_A,
        S_JOIN_B
    } t_state;

    function automatic logic [7:0] colour_letter(input t_colour c);
        logic [7:0] l;
        case (c)
            COL_GREEN:  l = LTR_G;
            COL_YELLOW: l = LTR_Y;
            COL_RED:    l = LTR_R;
            default:    l = LTR_O;
        endcase
        return l;
    endfunction

endpackage

/* rtl/core/slc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/slc_front.sv */
// Front end: accepts input requests and decodes them into queued operations.
// Depends on slc_pkg.
module slc_front
    import slc_pkg::*;
(
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_sender,
    input  logic [1:0] i_sender_type,
    input  logic [7:0] i_sender_net,
    input  logic [7:0] i_request,
    input  logic [7:0] i_clear_target,
    input  logic       i_q_full,
    output logic       o_in_ready,
    output logic       o_push,
    output t_op        o_op
);

    t_req     w_req;
    t_op_kind w_kind;
    logic     w_keep;

    // Decode request letter and clear target
    always_comb begin
        unique case (i_request)
            LTR_G: w_req = REQ_G;
            LTR_Y: w_req = REQ_Y;
            LTR_R: w_req = REQ_R;
            LTR_O: w_req = REQ_O;
            LTR_C: begin
                unique case (i_clear_target)
                    LTR_R:   w_req = REQ_CLR_R;
                    LTR_Y:   w_req = REQ_CLR_Y;
                    LTR_G:   w_req = REQ_CLR_G;
                    default: w_req = REQ_CLR_X;
                endcase
            end
            default: w_req = REQ_NONE;
        endcase
    end

    // Classify; drop requests that can have no effect
    always_comb begin
        w_kind = OP_JOIN;
        w_keep = 1'b0;
        unique case (i_cmd)
            CMD_MSG: begin
                if (i_sender_type == STYPE_CTRL) begin
                    // controller table is refreshed even for unknown letters
                    w_kind = OP_CTRL;
                    w_keep = 1'b1;
                end else if (i_sender_type == STYPE_SPECIAL) begin
                    w_kind = OP_SPECIAL;
                    w_keep = (w_req != REQ_NONE);
                end
            end
            CMD_FAULT: begin
                w_kind = OP_FAULT;
                w_keep = 1'b1;
            end
            CMD_JOIN: begin
                w_kind = OP_JOIN;
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready   = !i_q_full;
    assign o_push       = i_in_valid && !i_q_full && w_keep;
    assign o_op.kind    = w_kind;
    assign o_op.req     = w_req;
    assign o_op.sender  = i_sender;
    assign o_op.net     = i_sender_net;

endmodule

/* rtl/core/slc_queue.sv */
// Short FIFO of decoded operations between front and back end.
// Depends on slc_pkg.
module slc_queue
    import slc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_op    i_op,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_op              r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wptr;
    logic [QPW-1:0]   r_rptr;
    logic [QCW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Pointers wrap naturally; depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full       = (r_cnt == QCW'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.op    = r_mem[r_rptr];

endmodule

/* rtl/core/slc_back.sv */
// Back end: lockout state, controller table walks and result sequencing.
// Depends on slc_pkg and slc_ram.
module slc_back
    import slc_pkg::*;
#(
    parameter int MAX_CONTROLLERS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qhead     i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_code,
    output logic [7:0] o_target,
    output logic [7:0] o_mode,
    output logic       o_last
);

    localparam int IW     = (MAX_CONTROLLERS > 1) ? $clog2(MAX_CONTROLLERS) : 1;
    localparam int CW     = $clog2(MAX_CONTROLLERS + 1);
    localparam int SEEN_A = (MAX_CONTROLLERS < NET_SLOTS) ? MAX_CONTROLLERS : NET_SLOTS;
    localparam int SEEN   = (SEEN_A < MAX_RESULTS) ? SEEN_A : MAX_RESULTS;
    localparam int SW     = (SEEN > 1) ? $clog2(SEEN) : 1;
    localparam int UW     = $clog2(SEEN + 1);

    t_state        r_state, n_state;
    t_op           r_op;
    t_mode         r_mode;
    t_colour       r_req_col;
    t_colour       r_shown;
    logic          r_blocked;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [7:0]    r_conf;
    logic [UW-1:0] r_used;
    logic [SEEN-1:0] r_seen_v;
    logic [7:0]    r_seen_net [SEEN];
    logic [SEEN-1:0] r_match;
    logic [7:0]    r_cur_id;
    logic [7:0]    r_cur_net;
    logic [7:0]    r_pend_id;

    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_code;
    logic [7:0]    r_target;
    logic [7:0]    r_mode_out;
    logic          r_last;

    logic [7:0]    w_id_rdata;
    logic [7:0]    w_net_rdata;
    logic          w_we_id;
    logic          w_we_net;
    logic [IW-1:0] w_waddr;
    logic [SEEN-1:0] w_match;

    logic          w_load;
    logic          w_emit;
    logic [1:0]    e_kind;
    logic [7:0]    e_code;
    logic [7:0]    e_target;
    logic [7:0]    e_mode;
    logic          e_last;
    logic          w_cnt_inc;
    logic          w_idx_inc;
    logic          w_apply;
    logic          w_show;
    logic          w_block_set;
    logic          w_new;
    logic          w_go;
    logic          w_end;
    logic          w_take_new;
    logic          w_id_hit;

    t_mode         ap_mode;
    t_colour       ap_col;
    logic [7:0]    ap_conf;

    slc_ram #(.WIDTH(8), .DEPTH(MAX_CONTROLLERS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_id),
        .i_waddr (w_waddr),
        .i_wdata (r_op.sender),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_id_rdata)
    );

    slc_ram #(.WIDTH(8), .DEPTH(MAX_CONTROLLERS)) u_net_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_net),
        .i_waddr (w_waddr),
        .i_wdata (r_op.net),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_net_rdata)
    );

    assign w_load   = !r_out_valid || i_out_ready;
    assign w_id_hit = (w_id_rdata == r_op.sender);
    assign w_new    = ~|r_match;
    assign w_go     = !(w_new && (r_used != '0)) || w_load;
    assign w_end    = ((r_idx + CW'(1)) == r_count) ||
                      (w_new && ((r_used + UW'(1)) == UW'(SEEN)));
    assign w_take_new = (r_state == S_ERR_DECIDE) && w_go && w_new;

    // Compare the net just read against every net already served
    always_comb begin
        for (int k = 0; k < SEEN; k++) begin
            w_match[k] = r_seen_v[k] && (r_seen_net[k] == w_net_rdata);
        end
    end

    // Lockout rules for controller and special-device requests
    always_comb begin
        ap_mode = r_mode;
        ap_col  = r_req_col;
        ap_conf = CONF_NONE;
        if (r_op.kind == OP_SPECIAL) begin
            case (r_op.req)
                REQ_R: begin
                    ap_mode = MODE_STOP;   ap_col = COL_RED;    ap_conf = CONF_R;
                end
                REQ_Y: begin
                    ap_mode = MODE_YELLOW; ap_col = COL_YELLOW; ap_conf = CONF_Y;
                end
                REQ_O: begin
                    ap_mode = MODE_CLEAR;  ap_col = COL_OFF;    ap_conf = CONF_O;
                end
                REQ_CLR_R, REQ_CLR_Y, REQ_CLR_G, REQ_CLR_X: begin
                    ap_mode = MODE_CLEAR;  ap_conf = CONF_C;
                end
                default: ap_conf = CONF_NONE;
            endcase
        end else begin
            case (r_op.req)
                REQ_G: begin
                    if (r_mode == MODE_CLEAR || r_mode == MODE_GREEN) begin
                        ap_mode = MODE_GREEN; ap_col = COL_GREEN; ap_conf = CONF_G;
                    end
                end
                REQ_Y: begin
                    if (r_mode == MODE_CLEAR || r_mode == MODE_GREEN ||
                        r_mode == MODE_YELLOW) begin
                        ap_mode = MODE_YELLOW; ap_col = COL_YELLOW; ap_conf = CONF_Y;
                    end
                end
                REQ_R: begin
                    // red is honored in every mode, stop included
                    ap_mode = MODE_RED; ap_col = COL_RED; ap_conf = CONF_R;
                end
                REQ_CLR_R: begin
                    if (r_mode == MODE_CLEAR || r_mode == MODE_RED) begin
                        ap_mode = MODE_CLEAR; ap_conf = CONF_C;
                    end
                end
                REQ_CLR_Y: begin
                    if (r_mode == MODE_GREEN) begin
                        ap_col = COL_YELLOW;
                    end
                    if (r_mode == MODE_CLEAR || r_mode == MODE_GREEN ||
                        r_mode == MODE_YELLOW) begin
                        ap_mode = MODE_CLEAR; ap_conf = CONF_C;
                    end
                end
                REQ_CLR_G: begin
                    if (r_mode == MODE_CLEAR || r_mode == MODE_GREEN) begin
                        ap_mode = MODE_CLEAR; ap_conf = CONF_C;
                    end
                end
                default: ap_conf = CONF_NONE;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.op.kind)
                        OP_CTRL:    n_state = S_SRCH_RD;
                        OP_SPECIAL: n_state = S_APPLY;
                        OP_FAULT:   n_state = (r_blocked || r_count == '0) ? S_IDLE : S_ERR_RD;
                        OP_JOIN:    n_state = S_JOIN_A;
                    endcase
                end
            end
            S_SRCH_RD:    n_state = (r_idx == r_count) ? S_APPLY : S_SRCH_CMP;
            S_SRCH_CMP:   n_state = w_id_hit ? S_APPLY : S_SRCH_RD;
            S_APPLY:      n_state = S_CONF;
            S_CONF: begin
                if (r_conf == CONF_NONE || w_load) begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                if (r_req_col == r_shown) begin
                    n_state = S_IDLE;
                end else if (w_load) begin
                    n_state = (r_req_col == COL_OFF) ? S_IDLE : S_SOLID;
                end
            end
            S_SOLID:      n_state = w_load ? S_IDLE : S_SOLID;
            S_ERR_RD:     n_state = S_ERR_MATCH;
            S_ERR_MATCH:  n_state = S_ERR_DECIDE;
            S_ERR_DECIDE: begin
                if (w_go) begin
                    n_state = w_end ? S_ERR_LAST : S_ERR_RD;
                end
            end
            S_ERR_LAST:   n_state = w_load ? S_IDLE : S_ERR_LAST;
            S_JOIN_A:     n_state = w_load ? S_JOIN_B : S_JOIN_A;
            S_JOIN_B:     n_state = w_load ? S_IDLE : S_JOIN_B;
            default:      n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        e_kind      = KIND_CONF;
        e_code      = 8'h00;
        e_target    = 8'h00;
        e_mode      = 8'h00;
        e_last      = 1'b0;
        w_we_id     = 1'b0;
        w_we_net    = 1'b0;
        w_waddr     = r_idx[IW-1:0];
        w_cnt_inc   = 1'b0;
        w_idx_inc   = 1'b0;
        w_apply     = 1'b0;
        w_show      = 1'b0;
        w_block_set = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = i_head.valid;
            end
            S_SRCH_RD: begin
                // end of table: append when there is room
                if (r_idx == r_count && r_count < CW'(MAX_CONTROLLERS)) begin
                    w_we_id   = 1'b1;
                    w_we_net  = 1'b1;
                    w_waddr   = r_count[IW-1:0];
                    w_cnt_inc = 1'b1;
                end
            end
            S_SRCH_CMP: begin
                if (w_id_hit) begin
                    w_we_net = 1'b1;
                end else begin
                    w_idx_inc = 1'b1;
                end
            end
            S_APPLY: begin
                w_apply = 1'b1;
            end
            S_CONF: begin
                if (r_conf != CONF_NONE) begin
                    w_emit   = w_load;
                    e_kind   = KIND_CONF;
                    e_code   = r_conf;
                    e_target = r_op.sender;
                    e_last   = (r_req_col == r_shown);
                end
            end
            S_OFF: begin
                if (r_req_col != r_shown) begin
                    w_emit      = w_load;
                    e_kind      = KIND_IND;
                    e_target    = ALL_TARGET;
                    e_mode      = LTR_O;
                    e_last      = (r_req_col == COL_OFF);
                    w_block_set = w_load;
                    w_show      = w_load && (r_req_col == COL_OFF);
                end
            end
            S_SOLID: begin
                w_emit = w_load;
                e_kind = KIND_IND;
                e_code = colour_letter(r_req_col);
                e_mode = LTR_S;
                e_last = 1'b1;
                w_show = w_load;
            end
            S_ERR_RD, S_ERR_MATCH: begin
                w_emit = 1'b0;
            end
            S_ERR_DECIDE: begin
                // release the held error once another one is known to follow
                if (w_new && r_used != '0) begin
                    w_emit   = w_load;
                    e_kind   = KIND_ERR;
                    e_code   = colour_letter(r_shown);
                    e_target = r_pend_id;
                end
                w_idx_inc = w_go;
            end
            S_ERR_LAST: begin
                w_emit   = w_load;
                e_kind   = KIND_ERR;
                e_code   = colour_letter(r_shown);
                e_target = r_pend_id;
                e_last   = 1'b1;
            end
            S_JOIN_A, S_JOIN_B: begin
                w_emit = w_load;
                e_kind = KIND_JOIN;
                e_code = JOIN_CODE;
                e_last = (r_state == S_JOIN_B);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_CLEAR;
            r_req_col   <= COL_OFF;
            r_shown     <= COL_OFF;
            r_blocked   <= 1'b1;
            r_count     <= '0;
            r_idx       <= '0;
            r_used      <= '0;
            r_seen_v    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= '0;
                if (i_head.op.kind == OP_FAULT) begin
                    r_blocked <= 1'b0;
                    r_used    <= '0;
                    r_seen_v  <= '0;
                end
            end
            if (w_cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (w_idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_apply) begin
                r_mode    <= ap_mode;
                r_req_col <= ap_col;
            end
            if (w_block_set) begin
                r_blocked <= 1'b1;
            end
            if (w_show) begin
                r_shown <= r_req_col;
            end
            if (w_take_new) begin
                r_seen_v[r_used[SW-1:0]] <= 1'b1;
                r_used <= r_used + UW'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head.op;
        end
        if (w_apply) begin
            r_conf <= ap_conf;
        end
        if (r_state == S_ERR_MATCH) begin
            r_cur_id  <= w_id_rdata;
            r_cur_net <= w_net_rdata;
            r_match   <= w_match;
        end
        if (w_take_new) begin
            r_pend_id                  <= r_cur_id;
            r_seen_net[r_used[SW-1:0]] <= r_cur_net;
        end
        if (w_emit) begin
            r_kind     <= e_kind;
            r_code     <= e_code;
            r_target   <= e_target;
            r_mode_out <= e_mode;
            r_last     <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_code      = r_code;
    assign o_target    = r_target;
    assign o_mode      = r_mode_out;
    assign o_last      = r_last;

endmodule

/* rtl/core/signal_light_lockout_controller.sv */
// Top level of the signal light lockout controller: front decoder, queue, back end.
// Depends on slc_pkg, slc_front, slc_queue, slc_back and slc_ram.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_cmd i_sender i_sender_type
//                                                  i_sender_net i_request i_clear_target
//  output    out        o_out_valid / i_out_ready  o_kind o_code o_target o_mode o_last
//
// A request is decoded combinationally by the front end and waits in a two-entry
// queue; the back end handles one request at a time. Controller messages search the
// table one entry per read (states SRCH_RD, SRCH_CMP); lamp fault samples walk it
// through ERR_RD, ERR_MATCH and ERR_DECIDE for each entry; join requests send a pair
// of join results. A stalled output holds any of these steps that emits a result.
// Reset is synchronous and active low; it clears all control state. The table RAMs
// are not cleared: only entries below the fill count are read.
// A stalled output holds the back end; the front keeps taking requests until the
// queue is full.
module signal_light_lockout_controller
    import slc_pkg::*;
#(
    parameter int MAX_CONTROLLERS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_sender,
    input  logic [1:0] i_sender_type,
    input  logic [7:0] i_sender_net,
    input  logic [7:0] i_request,
    input  logic [7:0] i_clear_target,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_code,
    output logic [7:0] o_target,
    output logic [7:0] o_mode,
    output logic       o_last
);

    logic   w_q_full;
    logic   w_push;
    t_op    w_op;
    logic   w_pop;
    t_qhead w_head;

    // Decode each request; drop those that can have no effect
    slc_front u_front (
        .i_in_valid     (i_in_valid),
        .i_cmd          (i_cmd),
        .i_sender       (i_sender),
        .i_sender_type  (i_sender_type),
        .i_sender_net   (i_sender_net),
        .i_request      (i_request),
        .i_clear_target (i_clear_target),
        .i_q_full       (w_q_full),
        .o_in_ready     (o_in_ready),
        .o_push         (w_push),
        .o_op           (w_op)
    );

    // Hold decoded requests so front and back stall independently
    slc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // Apply lockout rules, walk the controller table, sequence results
    slc_back #(
        .MAX_CONTROLLERS (MAX_CONTROLLERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_code      (o_code),
        .o_target    (o_target),
        .o_mode      (o_mode),
        .o_last      (o_last)
    );

endmodule

/* rtl/core/slc_checker.sv */
// Port-level checks of the signal light lockout controller, bound to the top level.
// Depends on slc_pkg and signal_light_lockout_controller.
module slc_port_checks
    import slc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_code,
    input logic [7:0] o_target,
    input logic [7:0] o_mode,
    input logic       o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_code) && $stable(o_target) && $stable(o_mode) && $stable(o_last))
        else $error("stalled result changed");

    // Drop any result on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Indicator commands are either all-off or a solid colour
    a_ind_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_IND |->
        (o_mode == LTR_O && o_code == 8'h00 && o_target == ALL_TARGET) ||
        (o_mode == LTR_S && o_target == 8'h00 &&
         (o_code == LTR_G || o_code == LTR_Y || o_code == LTR_R)))
        else $error("malformed indicator command");

    // Join messages come in back-to-back pairs
    a_join_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind == KIND_JOIN && !o_last |=>
        o_out_valid && o_kind == KIND_JOIN && o_last)
        else $error("join pair broken");

    // Confirmations carry a known letter and no mode
    a_conf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_CONF |-> o_mode == 8'h00 &&
        (o_code == CONF_G || o_code == CONF_Y || o_code == CONF_R ||
         o_code == CONF_O || o_code == CONF_C))
        else $error("malformed confirmation");

endmodule

bind signal_light_lockout_controller slc_port_checks u_slc_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_code      (o_code),
    .o_target    (o_target),
    .o_mode      (o_mode),
    .o_last      (o_last)
);
